[rtl/dart_pkg.sv]
// ----------------------------------------------------------------------------
// dart_pkg: shared definitions for the divider and reloading timer
// Field widths, register indexes and the period decoder of the clock select.
// ----------------------------------------------------------------------------
`default_nettype none

package dart_pkg;

  localparam int unsigned ElapsedW  = 6;
  localparam int unsigned DividerW  = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PrescaleW = 9;
  localparam int unsigned SelW      = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TIMER_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CLOCK_SELECT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RELOAD_VALUE = 2'd2;

  // Clock select codes
  localparam logic [SelW-1:0] SEL_256 = 2'd0;
  localparam logic [SelW-1:0] SEL_4   = 2'd1;
  localparam logic [SelW-1:0] SEL_16  = 2'd2;
  localparam logic [SelW-1:0] SEL_64  = 2'd3;

  typedef logic [PrescaleW-1:0] prescale_t;

  function automatic prescale_t period_of(input logic [SelW-1:0] sel);
    prescale_t p;
    unique case (sel)
      SEL_4:   p = 9'd4;
      SEL_16:  p = 9'd16;
      SEL_64:  p = 9'd64;
      SEL_256: p = 9'd256;
      default: p = 9'd256;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/divider_and_reloading_timer_top.sv]
// ----------------------------------------------------------------------------
// divider_and_reloading_timer_top: free-running divider and reloading timer
//
//   channel | direction | handshake            | payload
//   in_     | sink      | in_tvalid/in_tready  | in_tdata  : elapsed clocks
//   out_    | source    | out_tvalid/out_tready| out_tdata : divider, counter, irq
//   cfg_    | sink      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// With the timer enabled, an item is accepted and then consumes its whole periods
// (up to 79 at the shortest period), one per cycle through a single prescale
// subtractor, before its result is written out; a disabled timer skips the periods.
// The result sits in an output register, so a stalled result only holds the
// block once the next item is finished. Reset (rst_n, synchronous) clears all
// counters, the configuration and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module divider_and_reloading_timer_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // slave side
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [dart_pkg::InDataW-1:0] in_tdata,   // [5:0] elapsed_clocks
  // master side
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [dart_pkg::OutDataW-1:0]     out_tdata,  // [7:0] divider_value,
                                                        // [15:8] counter_value,
                                                        // [16] timer_interrupt
  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [dart_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dart_pkg::ByteW-1:0]   cfg_data
);

  import dart_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [DividerW-1:0]   divider_r, divider_nxt;
  prescale_t             prescale_r, prescale_nxt;
  logic [ByteW-1:0]      count_r, count_nxt;
  logic                  irq_r, irq_nxt;

  logic                  enable_r;
  logic [SelW-1:0]       sel_r;
  logic [ByteW-1:0]      reload_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0]   out_data_r, out_data_nxt;

  logic                  in_acc;
  logic                  out_free;
  logic [PrescaleW:0]    diff;
  logic                  whole_period;
  logic [ElapsedW-1:0]   elapsed;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;
  assign elapsed    = in_tdata[ElapsedW-1:0];

  // shared subtractor: prescale minus the selected period
  assign diff         = {1'b0, prescale_r} - {1'b0, period_of(sel_r)};
  assign whole_period = !diff[PrescaleW];

  always_comb begin
    state_nxt     = state_r;
    divider_nxt   = divider_r;
    prescale_nxt  = prescale_r;
    count_nxt     = count_r;
    irq_nxt       = irq_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          divider_nxt = divider_r + DividerW'(elapsed);
          irq_nxt     = 1'b0;
          if (enable_r) begin
            prescale_nxt = prescale_r + PrescaleW'(elapsed);
            state_nxt    = S_RUN;
          end else begin
            state_nxt    = S_DONE;
          end
        end
      end
      S_RUN: begin
        if (whole_period) begin
          prescale_nxt = diff[PrescaleW-1:0];
          if (count_r == {ByteW{1'b1}}) begin
            count_nxt = reload_r;
            irq_nxt   = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, irq_r, count_r, divider_r[DividerW-1 -: ByteW]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      divider_r   <= '0;
      prescale_r  <= '0;
      count_r     <= '0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b0;
      sel_r       <= SEL_256;
      reload_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      divider_r   <= divider_nxt;
      prescale_r  <= prescale_nxt;
      count_r     <= count_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TIMER_ENABLE: enable_r <= cfg_data[0];
          REG_CLOCK_SELECT: sel_r    <= cfg_data[SelW-1:0];
          REG_RELOAD_VALUE: reload_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in progress");

  a_prescale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prescale_r < 9'd320)
    else $error("prescale count out of range");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the divider and reloading timer
// Drives elapsed-cycle requests with random gaps and back-pressure. It keeps
// its own divider, prescale and counter state to predict every result, and
// changes the registers only while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import dart_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 120;

  typedef struct packed {
    logic [OutDataW-18:0] pad;
    logic                 irq;
    logic [ByteW-1:0]     counter;
    logic [ByteW-1:0]     divider;
  } timer_result_t;

  class timer_tally;
    logic                 enable;
    logic [SelW-1:0]      sel;
    logic [ByteW-1:0]     reload;
    logic [DividerW-1:0]  divider;
    prescale_t            prescale;
    logic [ByteW-1:0]     count;
    timer_result_t        expected_results[$];
    int unsigned          fails;

    function new();
      enable   = 1'b0;
      sel      = SEL_256;
      reload   = '0;
      divider  = '0;
      prescale = '0;
      count    = '0;
      fails    = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] data);
      case (idx)
        REG_TIMER_ENABLE: enable = data[0];
        REG_CLOCK_SELECT: sel    = data[SelW-1:0];
        REG_RELOAD_VALUE: reload = data;
        default: ;
      endcase
    endfunction

    // Advance the divider always, the prescale and counter only when enabled.
    function void note_request(logic [ElapsedW-1:0] elapsed);
      timer_result_t r;
      prescale_t     period;
      logic          wrapped;
      wrapped = 1'b0;
      divider = divider + DividerW'(elapsed);
      if (enable) begin
        case (sel)
          SEL_4:   period = 9'd4;
          SEL_16:  period = 9'd16;
          SEL_64:  period = 9'd64;
          default: period = 9'd256;
        endcase
        prescale = prescale + PrescaleW'(elapsed);
        while (prescale >= period) begin
          prescale = prescale - period;
          if (count == 8'hFF) begin
            count   = reload;
            wrapped = 1'b1;
          end else begin
            count = count + 8'd1;
          end
        end
      end
      r.pad     = '0;
      r.irq     = wrapped;
      r.counter = count;
      r.divider = divider[DividerW-1:ByteW];
      expected_results.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch in %s: got %0h, want %0h", what, got, want);
      fails++;
    endtask

    task check_result(logic [OutDataW-1:0] data);
      timer_result_t got;
      timer_result_t want;
      got = data;
      if (expected_results.size() == 0) begin
        report("unexpected result", data, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.divider !== want.divider) report("divider_value", got.divider, want.divider);
        if (got.counter !== want.counter) report("counter_value", got.counter, want.counter);
        if (got.irq !== want.irq) report("timer_interrupt", got.irq, want.irq);
        if (got.pad !== want.pad) report("padding", got.pad, want.pad);
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ByteW-1:0]    cfg_data;

  timer_tally  tally;
  int unsigned quiet_cycles;
  int unsigned hold_off_cycles;
  logic        in_eager;
  logic        out_eager;

  divider_and_reloading_timer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    tally = new();
    clk   = 1'b0;
    forever #2 clk = ~clk;
  end

  // Observe every handshake at the rising edge and watch for a stuck block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tally.note_request(in_tdata[ElapsedW-1:0]);
      if (out_tvalid && out_tready) tally.check_result(out_tdata);
      if (cfg_valid && cfg_ready) tally.write_reg(cfg_index, cfg_data);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap();
    return in_eager ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [ElapsedW-1:0] draw_elapsed();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    case (pick)
      0:       return 6'd63;
      1:       return 6'd0;
      2:       return ElapsedW'($urandom_range(0, 3));
      default: return ElapsedW'($urandom_range(0, 63));
    endcase
  endfunction

  // Leave the valid high after the handshake so a gapless request follows on.
  task automatic send_request(input logic [ElapsedW-1:0] elapsed, input int unsigned gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(InDataW-ElapsedW){1'b0}}, elapsed};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (tally.pending() != 0) @(negedge clk);
  endtask

  // Result sink: random stall per request, or one long hold-off when asked.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      stall = out_eager ? 0 : $urandom_range(0, 8);
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned      items_sent;
    int unsigned      phase;
    int unsigned      burst;
    logic [ByteW-1:0] data;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_TIMER_ENABLE;
    cfg_data        = '0;
    quiet_cycles    = 0;
    hold_off_cycles = 0;
    in_eager        = 1'b0;
    out_eager       = 1'b0;
    items_sent      = 0;
    phase           = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Timer disabled: only the divider moves; the spare index must do nothing.
    send_request(6'd0, draw_gap());
    send_request(6'd63, draw_gap());
    wait_for_drain();
    write_register(REG_UNUSED, 8'hFF);
    send_request(6'd1, draw_gap());
    wait_for_drain();
    write_register(REG_TIMER_ENABLE, 8'h01);
    write_register(REG_CLOCK_SELECT, ByteW'(SEL_256));
    write_register(REG_RELOAD_VALUE, 8'hFF);
    repeat (4) send_request(6'd63, draw_gap());
    // Shorten the period with a large prescale left over.
    wait_for_drain();
    write_register(REG_CLOCK_SELECT, ByteW'(SEL_4));
    send_request(6'd63, draw_gap());
    // Run past 255 with a reload of 255, so every later increment wraps.
    repeat (12) send_request(6'd63, draw_gap());
    send_request(6'd0, draw_gap());
    send_request(6'd2, draw_gap());
    wait_for_drain();
    write_register(REG_RELOAD_VALUE, 8'h00);
    write_register(REG_TIMER_ENABLE, 8'h00);
    send_request(6'd63, draw_gap());

    while (items_sent < RandomItems) begin
      wait_for_drain();
      if (phase < 4 || $urandom_range(0, 2) != 0) begin
        data    = ByteW'($urandom_range(0, 255));
        data[0] = (phase < 4) || ($urandom_range(0, 3) != 0);
        write_register(REG_TIMER_ENABLE, data);
      end
      if (phase < 4 || $urandom_range(0, 2) == 0) begin
        data           = ByteW'($urandom_range(0, 255));
        data[SelW-1:0] = (phase < 4) ? SelW'(phase) : SelW'($urandom_range(0, 3));
        write_register(REG_CLOCK_SELECT, data);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          2:       data = 8'hFE;
          default: data = ByteW'($urandom_range(0, 255));
        endcase
        write_register(REG_RELOAD_VALUE, data);
      end
      if ($urandom_range(0, 7) == 0) write_register(REG_UNUSED, ByteW'($urandom_range(0, 255)));
      in_eager  = ($urandom_range(0, 3) == 0);
      out_eager = ($urandom_range(0, 3) == 0);
      burst     = $urandom_range(10, 60);
      if (phase == 2) begin
        // Stall the sink for a long stretch while requests keep coming.
        in_eager        = 1'b1;
        hold_off_cycles = HoldCycles;
      end
      repeat (burst) begin
        send_request(draw_elapsed(), draw_gap());
        items_sent++;
      end
      phase++;
    end

    wait_for_drain();
    repeat (TailCycles) @(negedge clk);
    if (tally.fails == 0 && tally.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/dart_pkg.sv
rtl/divider_and_reloading_timer_top.sv
sim/tb_top.sv
